@@ rtl/wfn_pkg.sv @@
// Shared types and constants for the wall following navigator.
// Sample and command payloads, config register set, mode codes, steering constants.
// No dependencies.
package wfn_pkg;

    localparam int RANGE_BITS     = 13;
    localparam int ANGLE_BITS     = 16;
    localparam int TOL_BITS       = ANGLE_BITS - 3;
    localparam int SPEED_BITS     = 10;
    localparam int TURN_BITS      = 11;
    localparam int RATE_BITS      = 12;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 24;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_SPEED         = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_RATE           = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_YAW_TOLERANCE       = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP_DISTANCE       = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_DISTANCE       = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_RANGE           = 8'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WALL_TARGET         = 8'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WALL_FOUND_DISTANCE = 8'd7;

    // config reset values
    localparam int RST_DRIVE_SPEED         = 200;
    localparam int RST_TURN_RATE           = 600;
    localparam int RST_YAW_TOLERANCE       = 521;
    localparam int RST_STOP_DISTANCE       = 400;
    localparam int RST_OPEN_DISTANCE       = 700;
    localparam int RST_MAX_RANGE           = 3500;
    localparam int RST_WALL_TARGET         = 300;
    localparam int RST_WALL_FOUND_DISTANCE = 350;

    localparam int SPEED_LIMIT = 1000;
    localparam int RATE_LIMIT  = 1500;

    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF    = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    // steering numerator n = 14000*T + 142*r - 10000*f (units of 1/20000 mrad/s)
    localparam int N_BITS      = RANGE_BITS + 17;
    localparam int K_TARGET    = 14000;
    localparam int K_RIGHT     = 142;
    localparam int K_FRONT     = 10000;
    localparam int N_SAT       = RATE_LIMIT * 20000;
    localparam int ROUND_BIAS  = 10000 + N_SAT;
    // x/20000 = (x>>5)/625, the latter by reciprocal ceil(2^31/625)
    localparam int DIV_SHIFT   = 5;
    localparam int Y_BITS      = 21;
    localparam int RECIP       = 3435974;
    localparam int RECIP_BITS  = 22;
    localparam int RECIP_SHIFT = 31;

    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_TURN    = 2'd1,
        MODE_FIND    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0]        right_range;
        logic [RANGE_BITS-1:0]        front_right_range;
        logic [RANGE_BITS-1:0]        front_range;
        logic [RANGE_BITS-1:0]        left_range;
        logic signed [ANGLE_BITS-1:0] heading;
        logic                         goal_colour_seen;
        logic                         suppress_right_turn;
    } sample_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0]       linear_speed;
        logic signed [RATE_BITS-1:0] angular_rate;
    } command_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0] drive_speed;
        logic [TURN_BITS-1:0]  turn_rate;
        logic [TOL_BITS-1:0]   yaw_tolerance;
        logic [RANGE_BITS-1:0] stop_distance;
        logic [RANGE_BITS-1:0] open_distance;
        logic [RANGE_BITS-1:0] max_range;
        logic [RANGE_BITS-1:0] wall_target;
        logic [RANGE_BITS-1:0] wall_found_distance;
    } cfg_t;

    // decision for one sample, before the steering rate is known
    typedef struct packed {
        logic [SPEED_BITS-1:0]       speed;
        logic                        use_steer;
        logic signed [RATE_BITS-1:0] rate;
    } decide_t;

endpackage

@@ rtl/wall_following_navigator.sv @@
// Right-hand wall follower: one motion command per sensor sample.
// A sample passes through the input, decide, divide and output registers, in that order, to m_valid.
// Throughput: one sample per cycle while m_ready stays high; the four-register pipeline (input, decide,
// divide, output) sets it, each stage holding while its successor is full and stalled.
// Reset (aresetn low, synchronous): pipeline empty, forward mode, target 0,
// not finished, config registers to their defaults.
module wall_following_navigator import wfn_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    // sample channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  sample_t                   s_data,
    // command channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output command_t                  m_data,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // ---------------- config registers ----------------
    // Speeds are clamped on write, so the datapath only sees legal values.
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_speed         <= SPEED_BITS'(RST_DRIVE_SPEED);
            cfg_reg.turn_rate           <= TURN_BITS'(RST_TURN_RATE);
            cfg_reg.yaw_tolerance       <= TOL_BITS'(RST_YAW_TOLERANCE);
            cfg_reg.stop_distance       <= RANGE_BITS'(RST_STOP_DISTANCE);
            cfg_reg.open_distance       <= RANGE_BITS'(RST_OPEN_DISTANCE);
            cfg_reg.max_range           <= RANGE_BITS'(RST_MAX_RANGE);
            cfg_reg.wall_target         <= RANGE_BITS'(RST_WALL_TARGET);
            cfg_reg.wall_found_distance <= RANGE_BITS'(RST_WALL_FOUND_DISTANCE);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DRIVE_SPEED: begin
                    cfg_reg.drive_speed <=
                        (cfg_data[SPEED_BITS-1:0] > SPEED_BITS'(SPEED_LIMIT)) ?
                        SPEED_BITS'(SPEED_LIMIT) : cfg_data[SPEED_BITS-1:0];
                end
                CFG_TURN_RATE: begin
                    cfg_reg.turn_rate <=
                        (cfg_data[TURN_BITS-1:0] > TURN_BITS'(RATE_LIMIT)) ?
                        TURN_BITS'(RATE_LIMIT) : cfg_data[TURN_BITS-1:0];
                end
                CFG_YAW_TOLERANCE:       cfg_reg.yaw_tolerance <= cfg_data[TOL_BITS-1:0];
                CFG_STOP_DISTANCE:       cfg_reg.stop_distance <= cfg_data[RANGE_BITS-1:0];
                CFG_OPEN_DISTANCE:       cfg_reg.open_distance <= cfg_data[RANGE_BITS-1:0];
                CFG_MAX_RANGE:           cfg_reg.max_range     <= cfg_data[RANGE_BITS-1:0];
                CFG_WALL_TARGET:         cfg_reg.wall_target   <= cfg_data[RANGE_BITS-1:0];
                CFG_WALL_FOUND_DISTANCE: begin
                    cfg_reg.wall_found_distance <= cfg_data[RANGE_BITS-1:0];
                end
                default: ; // unknown index: write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Each stage takes a new item when empty or when its own item moves on.
    logic in_valid_reg, st1_valid_reg, st2_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = !out_valid_reg || m_ready;
    assign rdy2    = !st2_valid_reg || rdy3;
    assign rdy1    = !st1_valid_reg || rdy2;
    assign s_ready = !in_valid_reg  || rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg  <= s_valid;
            if (rdy1)    st1_valid_reg <= in_valid_reg;
            if (rdy2)    st2_valid_reg <= st1_valid_reg;
            if (rdy3)    out_valid_reg <= st2_valid_reg;
        end
    end

    // ---------------- input register ----------------
    sample_t in_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // ---------------- decide stage ----------------
    // Mode state commits when the sample leaves the input register, so the
    // next sample, held in the input register behind it, sees the updated mode and target.
    decide_t cmd_next;
    decide_t cmd1_reg, cmd2_reg;
    logic    advance;

    assign advance = in_valid_reg && rdy1;

    wfn_mode_ctrl u_mode_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sample  (in_reg),
        .cfg     (cfg_reg),
        .advance (advance),
        .cmd     (cmd_next)
    );

    // steering runs alongside: numerator with stage 1, quotient with stage 2
    logic signed [RATE_BITS-1:0] steer_rate;

    wfn_steer u_steer (
        .aclk              (aclk),
        .right_range       (in_reg.right_range),
        .front_right_range (in_reg.front_right_range),
        .wall_target       (cfg_reg.wall_target),
        .load_n            (rdy1),
        .load_q            (rdy2),
        .steer_rate        (steer_rate)
    );

    always_ff @(posedge aclk) begin
        if (rdy1) cmd1_reg <= cmd_next;
        if (rdy2) cmd2_reg <= cmd1_reg;
    end

    // ---------------- output register ----------------
    command_t out_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            out_reg.linear_speed <= cmd2_reg.speed;
            out_reg.angular_rate <= cmd2_reg.use_steer ? steer_rate : cmd2_reg.rate;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ---------------- assertions ----------------
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.linear_speed <= SPEED_BITS'(SPEED_LIMIT)) &&
                    (m_data.angular_rate <= RATE_BITS'(RATE_LIMIT)) &&
                    (m_data.angular_rate >= -RATE_BITS'(RATE_LIMIT)))
        else $error("command out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && st1_valid_reg && st2_valid_reg && out_valid_reg && !m_ready)
        |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted sample lost");

    a_fixed_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (st2_valid_reg && !cmd2_reg.use_steer && cmd2_reg.speed != '0)
        |-> (cmd2_reg.rate == '0))
        else $error("driving command with a turn rate");

endmodule

@@ rtl/wfn_mode_ctrl.sv @@
// Drive mode machine: forward / turn / find wall, target heading, finished flag.
// Depends on wfn_pkg.
module wfn_mode_ctrl import wfn_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  sample_t sample,
    input  cfg_t    cfg,
    input  logic    advance,
    output decide_t cmd
);

    mode_t                 mode_reg, mode_next;
    logic [ANGLE_BITS-1:0] target_reg, target_next;
    logic                  finished_reg, finished_next;

    logic [ANGLE_BITS-1:0]       head;
    logic [ANGLE_BITS-1:0]       err;
    logic [ANGLE_BITS-1:0]       mag;
    logic                        positive;
    logic signed [RATE_BITS-1:0] turn_rate_s;
    logic                        right_gap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_FORWARD;
            target_reg   <= '0;
            finished_reg <= 1'b0;
        end else if (advance) begin
            mode_reg     <= mode_next;
            target_reg   <= target_next;
            finished_reg <= finished_next;
        end
    end

    always_comb begin
        head        = sample.heading;
        err         = target_reg - head;
        positive    = (err != '0) && (err <= ANGLE_HALF);
        mag         = (err > ANGLE_HALF) ? (~err + 1'b1) : err;
        turn_rate_s = signed'(RATE_BITS'(cfg.turn_rate));
        right_gap   = (sample.right_range > cfg.open_distance) &&
                      (sample.right_range < cfg.max_range);

        mode_next     = mode_reg;
        target_next   = target_reg;
        finished_next = finished_reg;
        cmd           = '0;

        if (finished_reg || sample.goal_colour_seen) begin
            finished_next = 1'b1;
        end else begin
            unique case (mode_reg)
                MODE_TURN: begin
                    if (mag < ANGLE_BITS'(cfg.yaw_tolerance)) begin
                        mode_next = MODE_FIND;
                    end else begin
                        cmd.rate = positive ? turn_rate_s : -turn_rate_s;
                    end
                end
                MODE_FIND: begin
                    if (sample.right_range <= cfg.wall_found_distance) begin
                        mode_next = MODE_FORWARD;
                    end else begin
                        cmd.speed = cfg.drive_speed;
                    end
                end
                default: begin
                    if (right_gap && !sample.suppress_right_turn) begin
                        mode_next   = MODE_TURN;
                        target_next = head - ANGLE_QUARTER;
                    end else if (sample.front_range > cfg.stop_distance) begin
                        mode_next     = MODE_FORWARD;
                        cmd.speed     = cfg.drive_speed;
                        cmd.use_steer = 1'b1;
                    end else if (sample.left_range > cfg.open_distance) begin
                        mode_next   = MODE_TURN;
                        target_next = head + ANGLE_QUARTER;
                    end else begin
                        mode_next   = MODE_TURN;
                        target_next = head + ANGLE_HALF;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/wfn_steer.sv @@
// Wall steering rate: numerator stage, then round-divide by 20000 and saturate.
// Depends on wfn_pkg.
module wfn_steer import wfn_pkg::*; (
    input  logic                        aclk,
    input  logic [RANGE_BITS-1:0]       right_range,
    input  logic [RANGE_BITS-1:0]       front_right_range,
    input  logic [RANGE_BITS-1:0]       wall_target,
    input  logic                        load_n,
    input  logic                        load_q,
    output logic signed [RATE_BITS-1:0] steer_rate
);

    localparam int P_BITS = Y_BITS + RECIP_BITS;
    localparam logic signed [N_BITS-1:0] SAT_P = N_BITS'(N_SAT);
    localparam logic signed [N_BITS-1:0] SAT_N = -SAT_P;

    logic signed [N_BITS-1:0]  n_next, n_reg;
    logic signed [N_BITS-1:0]  t_s, r_s, f_s;
    logic signed [N_BITS-1:0]  x;
    logic [Y_BITS-1:0]         y;
    logic [P_BITS-1:0]         prod;
    logic [RATE_BITS-1:0]      q_reg;
    logic                      sat_hi_reg, sat_lo_reg;
    logic signed [RATE_BITS:0] diff;

    // stage 1: constant-gain numerator
    always_comb begin
        t_s    = signed'(N_BITS'(wall_target));
        r_s    = signed'(N_BITS'(right_range));
        f_s    = signed'(N_BITS'(front_right_range));
        n_next = t_s * N_BITS'(K_TARGET) + r_s * N_BITS'(K_RIGHT)
               - f_s * N_BITS'(K_FRONT);
    end

    always_ff @(posedge aclk) begin
        if (load_n) begin
            n_reg <= n_next;
        end
    end

    // stage 2: biased value is positive below saturation, so floor division is plain
    always_comb begin
        x    = n_reg + N_BITS'(ROUND_BIAS);
        y    = x[DIV_SHIFT +: Y_BITS];
        prod = P_BITS'(y) * P_BITS'(RECIP);
    end

    always_ff @(posedge aclk) begin
        if (load_q) begin
            q_reg      <= prod[RECIP_SHIFT +: RATE_BITS];
            sat_hi_reg <= (n_reg >= SAT_P);
            sat_lo_reg <= (n_reg <= SAT_N);
        end
    end

    always_comb begin
        diff = signed'({1'b0, q_reg}) - (RATE_BITS+1)'(RATE_LIMIT);
        if (sat_hi_reg) begin
            steer_rate = RATE_BITS'(RATE_LIMIT);
        end else if (sat_lo_reg) begin
            steer_rate = -RATE_BITS'(RATE_LIMIT);
        end else begin
            steer_rate = diff[RATE_BITS-1:0];
        end
    end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for wall_following_navigator: sensor samples in, motion commands out.
// Holds its own copy of the navigator's mode machine and registers to predict each command.
// Depends on rtl/wfn_pkg.sv (payload structs, register indexes, mode codes, limits).
module testbench import wfn_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANGE_MAX       = (1 << RANGE_BITS) - 1;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;    // margin beyond the pipeline depth
    localparam int REG_COUNT       = 8;
    localparam int INDEX_MAX       = (1 << CFG_INDEX_BITS) - 1;

    // steering gains scaled by 20000 so the law stays in integers
    localparam longint STEER_K_ERR   = 14000;
    localparam longint STEER_K_RIGHT = 14142;
    localparam longint STEER_K_FRONT = 10000;
    localparam longint STEER_SCALE   = 20000;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    sample_t                   s_data;
    logic                      m_valid;
    logic                      m_ready;
    command_t                  m_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // navigator state as the bench sees it
    cfg_t                  nav_regs;
    mode_t                 nav_mode;
    logic [ANGLE_BITS-1:0] turn_target;
    logic                  run_finished;

    command_t expected_cmds[$];
    int       mismatch_count;

    // pacing knobs shared between the stimulus and the sink
    bit src_gaps;
    bit sink_gaps;
    bit hold_off_req;

    wall_following_navigator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic cfg_t default_regs();
        cfg_t c;
        c.drive_speed         = SPEED_BITS'(RST_DRIVE_SPEED);
        c.turn_rate           = TURN_BITS'(RST_TURN_RATE);
        c.yaw_tolerance       = TOL_BITS'(RST_YAW_TOLERANCE);
        c.stop_distance       = RANGE_BITS'(RST_STOP_DISTANCE);
        c.open_distance       = RANGE_BITS'(RST_OPEN_DISTANCE);
        c.max_range           = RANGE_BITS'(RST_MAX_RANGE);
        c.wall_target         = RANGE_BITS'(RST_WALL_TARGET);
        c.wall_found_distance = RANGE_BITS'(RST_WALL_FOUND_DISTANCE);
        return c;
    endfunction

    // register write as the block applies it: low bits kept, unknown index dropped
    function automatic void store_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            CFG_DRIVE_SPEED:         nav_regs.drive_speed         = val[SPEED_BITS-1:0];
            CFG_TURN_RATE:           nav_regs.turn_rate           = val[TURN_BITS-1:0];
            CFG_YAW_TOLERANCE:       nav_regs.yaw_tolerance       = val[TOL_BITS-1:0];
            CFG_STOP_DISTANCE:       nav_regs.stop_distance       = val[RANGE_BITS-1:0];
            CFG_OPEN_DISTANCE:       nav_regs.open_distance       = val[RANGE_BITS-1:0];
            CFG_MAX_RANGE:           nav_regs.max_range           = val[RANGE_BITS-1:0];
            CFG_WALL_TARGET:         nav_regs.wall_target         = val[RANGE_BITS-1:0];
            CFG_WALL_FOUND_DISTANCE: nav_regs.wall_found_distance = val[RANGE_BITS-1:0];
            default: ;
        endcase
    endfunction

    // wall-following yaw rate in mrad/s, saturated, rounded half up
    function automatic int steer_rate(input logic [RANGE_BITS-1:0] r,
                                      input logic [RANGE_BITS-1:0] f);
        longint n;
        longint sat;
        sat = longint'(RATE_LIMIT) * STEER_SCALE;
        n = STEER_K_ERR * (longint'(nav_regs.wall_target) - longint'(r))
          + STEER_K_RIGHT * longint'(r) - STEER_K_FRONT * longint'(f);
        if (n >= sat)
            return RATE_LIMIT;
        if (n <= -sat)
            return -RATE_LIMIT;
        // shift up so the division floors on a positive number
        return int'((n + STEER_SCALE / 2 + sat) / STEER_SCALE) - RATE_LIMIT;
    endfunction

    // command for one sample; advances the mode machine
    function automatic command_t predict_command(input sample_t smp);
        command_t              cmd;
        logic [ANGLE_BITS-1:0] head;
        logic [ANGLE_BITS-1:0] err;
        logic [ANGLE_BITS-1:0] mag;
        logic                  toward_left;
        logic [SPEED_BITS-1:0] cruise;
        int                    spin;
        cmd    = '0;
        head   = smp.heading;
        cruise = (nav_regs.drive_speed > SPEED_LIMIT) ? SPEED_BITS'(SPEED_LIMIT)
                                                      : nav_regs.drive_speed;
        spin   = (nav_regs.turn_rate > RATE_LIMIT) ? RATE_LIMIT : int'(nav_regs.turn_rate);
        if (smp.goal_colour_seen)
            run_finished = 1'b1;
        if (run_finished)
            return cmd;
        case (nav_mode)
            MODE_TURN: begin
                err = turn_target - head;
                // exactly half a turn counts as a left turn
                toward_left = (err != '0) && (err <= ANGLE_HALF);
                mag = (err > ANGLE_HALF) ? -err : err;
                if (mag < nav_regs.yaw_tolerance) begin
                    nav_mode = MODE_FIND;
                end else begin
                    cmd.angular_rate = toward_left ? RATE_BITS'(spin) : RATE_BITS'(-spin);
                end
            end
            MODE_FIND: begin
                if (smp.right_range <= nav_regs.wall_found_distance) begin
                    nav_mode = MODE_FORWARD;
                end else begin
                    cmd.linear_speed = cruise;
                end
            end
            default: begin
                if (smp.right_range > nav_regs.open_distance &&
                    smp.right_range < nav_regs.max_range && !smp.suppress_right_turn) begin
                    nav_mode    = MODE_TURN;
                    turn_target = head - ANGLE_QUARTER;
                end else if (smp.front_range > nav_regs.stop_distance) begin
                    nav_mode         = MODE_FORWARD;
                    cmd.linear_speed = cruise;
                    cmd.angular_rate = RATE_BITS'(steer_rate(smp.right_range,
                                                             smp.front_right_range));
                end else if (smp.left_range > nav_regs.open_distance) begin
                    nav_mode    = MODE_TURN;
                    turn_target = head + ANGLE_QUARTER;
                end else begin
                    nav_mode    = MODE_TURN;
                    turn_target = head + ANGLE_HALF;
                end
            end
        endcase
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic sample_t sample_of(input int r, input int fr, input int fwd,
                                          input int left, input logic [ANGLE_BITS-1:0] head,
                                          input bit skip);
        sample_t s;
        s.right_range         = RANGE_BITS'(r);
        s.front_right_range   = RANGE_BITS'(fr);
        s.front_range         = RANGE_BITS'(fwd);
        s.left_range          = RANGE_BITS'(left);
        s.heading             = head;
        s.goal_colour_seen    = 1'b0;
        s.suppress_right_turn = skip;
        return s;
    endfunction

    // range reading: anywhere, at a rail, or within a couple of mm of a threshold
    function automatic logic [RANGE_BITS-1:0] pick_range(input int unsigned mark_mm);
        int v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, RANGE_MAX);
            1:       v = 0;
            2:       v = RANGE_MAX;
            default: v = int'(mark_mm) + int'($urandom_range(0, 4)) - 2;
        endcase
        if (v < 0)
            v = 0;
        if (v > RANGE_MAX)
            v = RANGE_MAX;
        return RANGE_BITS'(v);
    endfunction

    // Random sample steered by the current mode so turns finish and walls get found;
    // about half the samples in turn mode and two thirds in find mode are left as plain noise.
    function automatic sample_t make_sample();
        sample_t s;
        int      span;
        int      off;
        case ($urandom_range(0, 2))
            0:       s.right_range = pick_range(nav_regs.open_distance);
            1:       s.right_range = pick_range(nav_regs.max_range);
            default: s.right_range = pick_range(nav_regs.wall_found_distance);
        endcase
        s.front_right_range   = pick_range(nav_regs.wall_target);
        s.front_range         = pick_range(nav_regs.stop_distance);
        s.left_range          = pick_range(nav_regs.open_distance);
        s.heading             = ANGLE_BITS'($urandom);
        s.goal_colour_seen    = 1'b0;
        s.suppress_right_turn = ($urandom_range(0, 3) == 0);
        if (nav_mode == MODE_TURN && $urandom_range(0, 1) == 1) begin
            // heading error spread around the tolerance band
            span = int'(nav_regs.yaw_tolerance) + 2;
            off = int'($urandom_range(0, 2 * span)) - span;
            s.heading = turn_target - ANGLE_BITS'(off);
        end
        if (nav_mode == MODE_FIND && $urandom_range(0, 2) == 0)
            s.right_range = RANGE_BITS'($urandom_range(0, nav_regs.wall_found_distance));
        return s;
    endfunction

    // One sample transfer. Entered and left just after a falling edge; valid stays
    // high between back-to-back samples and only drops for a sender gap.
    task automatic send_sample(input sample_t smp);
        int gap;
        gap = (src_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_cmds.push_back(predict_command(smp));
        @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_sample(make_sample());
    endtask

    // Stop offering and let every expected command come out before touching registers.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // cfg_valid held across consecutive writes; the caller drops it
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        store_reg(idx, val);
        @(negedge aclk);
    endtask

    // random junk above the register width; the block must ignore it
    function automatic logic [CFG_DATA_BITS-1:0] with_junk(input logic [CFG_DATA_BITS-1:0] v,
                                                           input int width);
        logic [CFG_DATA_BITS-1:0] keep;
        keep = ~({CFG_DATA_BITS{1'b1}} << width);
        return (CFG_DATA_BITS'($urandom) & ~keep) | (v & keep);
    endfunction

    task automatic program_regs(input cfg_t c);
        wait_drained();
        write_reg(CFG_DRIVE_SPEED,
                  with_junk(CFG_DATA_BITS'(c.drive_speed), SPEED_BITS));
        write_reg(CFG_TURN_RATE,
                  with_junk(CFG_DATA_BITS'(c.turn_rate), TURN_BITS));
        write_reg(CFG_YAW_TOLERANCE,
                  with_junk(CFG_DATA_BITS'(c.yaw_tolerance), TOL_BITS));
        write_reg(CFG_STOP_DISTANCE,
                  with_junk(CFG_DATA_BITS'(c.stop_distance), RANGE_BITS));
        write_reg(CFG_OPEN_DISTANCE,
                  with_junk(CFG_DATA_BITS'(c.open_distance), RANGE_BITS));
        write_reg(CFG_MAX_RANGE,
                  with_junk(CFG_DATA_BITS'(c.max_range), RANGE_BITS));
        write_reg(CFG_WALL_TARGET,
                  with_junk(CFG_DATA_BITS'(c.wall_target), RANGE_BITS));
        write_reg(CFG_WALL_FOUND_DISTANCE,
                  with_junk(CFG_DATA_BITS'(c.wall_found_distance), RANGE_BITS));
        // an index past the register file must change nothing
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_COUNT, INDEX_MAX)),
                  CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t random_regs();
        cfg_t c;
        c.drive_speed         = SPEED_BITS'($urandom);
        c.turn_rate           = TURN_BITS'($urandom);
        c.yaw_tolerance       = TOL_BITS'($urandom_range(0, (1 << TOL_BITS) - 1));
        c.stop_distance       = RANGE_BITS'($urandom_range(0, RANGE_MAX));
        c.open_distance       = RANGE_BITS'($urandom_range(0, RANGE_MAX));
        c.max_range           = RANGE_BITS'($urandom_range(0, RANGE_MAX));
        c.wall_target         = RANGE_BITS'($urandom_range(0, RANGE_MAX));
        c.wall_found_distance = RANGE_BITS'($urandom_range(0, RANGE_MAX));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers, hand-picked samples walking through every branch and threshold.
    task automatic test_reset_defaults();
        logic [ANGLE_BITS-1:0] tol;
        tol = ANGLE_BITS'(RST_YAW_TOLERANCE);
        send_sample(sample_of(300, 424, 401, 0, 16'h0000, 1'b0));        // drive, on target
        send_sample(sample_of(0, RANGE_MAX, RANGE_MAX, RANGE_MAX, 16'h0000, 1'b0)); // hard right sat
        send_sample(sample_of(3500, 0, RANGE_MAX, 0, 16'h0000, 1'b0));   // right at max: invalid
        send_sample(sample_of(701, 500, 401, 0, 16'h0000, 1'b1));        // opening suppressed
        // right quarter turn from the positive heading rail
        send_sample(sample_of(701, 500, 0, 0, 16'h7FFF, 1'b0));
        send_sample(sample_of(0, 0, 0, 0, 16'h8000, 1'b0));              // far off: turn right
        send_sample(sample_of(0, 0, 0, 0, 16'h3FFF + tol, 1'b0));         // error = -tolerance
        send_sample(sample_of(0, 0, 0, 0, 16'h3FFF - tol, 1'b0));         // error = +tolerance
        send_sample(sample_of(0, 0, 0, 0, 16'h3FFF - tol + 16'd1, 1'b0)); // inside: find wall
        send_sample(sample_of(351, 0, 0, 0, 16'h0000, 1'b0));            // no wall yet
        send_sample(sample_of(350, 0, 0, 0, 16'h0000, 1'b0));            // wall found
        // left quarter turn with front exactly at the stop distance
        send_sample(sample_of(700, 0, 400, 701, 16'h4000, 1'b0));
        send_sample(sample_of(RANGE_MAX, 0, 0, 0, 16'h0000, 1'b0));      // half-turn error: left
        send_sample(sample_of(RANGE_MAX, 0, 0, 0, 16'h8000, 1'b0));      // zero error: done
        send_sample(sample_of(0, 0, 0, 0, 16'h0000, 1'b0));
        // dead end: half turn
        send_sample(sample_of(RANGE_MAX, 0, 0, 700, 16'h1234, 1'b0));
        send_sample(sample_of(RANGE_MAX, 0, 0, 0, 16'h9234, 1'b0));
        send_sample(sample_of(0, 0, 0, 0, 16'h0000, 1'b0));
    endtask

    // All-zero and all-one register sets, then the speed clamps with steering saturation.
    task automatic test_register_extremes();
        cfg_t c;
        program_regs('0);
        run_random(40);
        program_regs('1);
        run_random(40);
        c = default_regs();
        c.drive_speed   = '1;
        c.turn_rate     = '1;
        c.stop_distance = '0;
        c.wall_target   = '1;
        program_regs(c);
        run_random(40);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            program_regs(random_regs());
            run_random(80);
        end
    endtask

    // Sink stalls for a long stretch while samples keep coming, filling the pipeline.
    task automatic test_backpressure();
        program_regs(default_regs());
        hold_off_req = 1'b1;
        src_gaps     = 1'b0;
        run_random(30);
        src_gaps     = 1'b1;
    endtask

    // Stretch at full rate on both sides.
    task automatic test_steady_stream();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_random(50);
    endtask

    // Goal seen: every later command is a stop, whatever the inputs.
    task automatic test_goal_latch();
        sample_t s;
        s = make_sample();
        s.goal_colour_seen = 1'b1;
        send_sample(s);
        repeat (20) begin
            s = make_sample();
            s.goal_colour_seen = 1'($urandom_range(0, 1));
            s.heading          = ANGLE_BITS'($urandom);
            send_sample(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Sink pacing: random stall bursts, or one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : sink_pacing
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command checker: each transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        command_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected command speed %0d rate %0d", $time,
                         m_data.linear_speed, m_data.angular_rate);
            end else begin
                want = expected_cmds.pop_front();
                if (m_data.linear_speed !== want.linear_speed) begin
                    mismatch_count++;
                    $display("%0t: linear_speed expected %0d actual %0d", $time,
                             want.linear_speed, m_data.linear_speed);
                end
                if (m_data.angular_rate !== want.angular_rate) begin
                    mismatch_count++;
                    $display("%0t: angular_rate expected %0d actual %0d", $time,
                             want.angular_rate, m_data.angular_rate);
                end
            end
        end
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        src_gaps       = 1'b1;
        sink_gaps      = 1'b1;
        hold_off_req   = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        nav_regs       = default_regs();
        nav_mode       = MODE_FORWARD;
        turn_target    = '0;
        run_finished   = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        test_goal_latch();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
